>>> design/gds_pkg.sv
`timescale 1ns / 1ps
package gds_pkg;

   localparam int NUM_ROWS    = 6;
   localparam int BIN_COLS    = 5;
   localparam int NUM_BINS    = 30;
   localparam int BITS_PER_COL = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] LAST_COL = 3'd7;
   localparam logic [2:0] LAST_ROW = 3'd5;
   localparam logic [7:0] ROW_MASK = 8'hF8;
   localparam logic [7:0] DENSE_LOW_RESET  = 8'd54;
   localparam logic [7:0] DENSE_HIGH_RESET = 8'd85;
   localparam logic [7:0] MAX_PIX_BEFORE_LAST = 8'd112;

   localparam logic CSR_DENSE_LOW  = 1'b0;
   localparam logic CSR_DENSE_HIGH = 1'b1;

   typedef struct packed {
      logic [7:0]  char_number;
      logic [15:0] column_bits;
   } gds_req_type;

   typedef struct packed {
      logic [7:0] out_char_number;
      logic [2:0] row_index;
      logic [7:0] row_bits;
      logic       last_row;
   } gds_rsp_type;

   typedef struct packed {
      logic [7:0]                     char_number;
      logic [7:0]                     pixel_count;
      logic [NUM_BINS-1:0][2:0]       bin_weights;
      logic [NUM_ROWS-1:0][7:0]       direct_rows;
   } gds_rec_type;

   typedef struct packed {
      logic        valid;
      gds_rec_type rec;
   } gds_qlink_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } gds_back_state_type;

   function automatic logic [2:0] bin_row_of_bit(input logic [3:0] u);
      logic [2:0] r;
      case (u) inside
         [4'd0:4'd2]:   r = 3'd5;
         [4'd3:4'd5]:   r = 3'd4;
         [4'd6:4'd7]:   r = 3'd3;
         [4'd8:4'd9]:   r = 3'd2;
         [4'd10:4'd12]: r = 3'd1;
         default:       r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] bin_col_of_col(input logic [2:0] col);
      logic [2:0] c;
      case (col) inside
         3'd0, 3'd1: c = 3'd0;
         3'd2:       c = 3'd1;
         3'd3, 3'd4: c = 3'd2;
         3'd5, 3'd6: c = 3'd3;
         default:    c = 3'd4;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] direct_mask(input logic [2:0] col);
      logic [7:0] m;
      case (col) inside
         3'd0, 3'd1: m = 8'h80;
         3'd2:       m = 8'h40;
         3'd3, 3'd4: m = 8'h20;
         3'd5, 3'd6: m = 8'h10;
         default:    m = 8'h08;
      endcase
      return m;
   endfunction

   function automatic logic [2:0] threshold(input logic [2:0] row, input logic [2:0] c);
      logic [2:0] t;
      t = (c == 3'd1 || c == 3'd4) ? 3'd2 : 3'd3;
      case (row) inside
         3'd2, 3'd3: t = t - 3'd1;
         default:    t = t;
      endcase
      return t;
   endfunction

endpackage

>>> design/gds_front.sv
`timescale 1ns / 1ps
module gds_front import gds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  gds_req_type   req_data,
   input  logic          q_full,
   output gds_qlink_type q_in
);

   logic [2:0]                col_ff, col_in;
   logic [7:0]                pix_ff, pix_in;
   logic [NUM_BINS-1:0][2:0]  bins_ff, bins_in;
   logic [NUM_ROWS-1:0][7:0]  rows_ff, rows_in;
   logic [NUM_ROWS-1:0][1:0]  grp_cnt;
   logic [4:0]                col_pop;
   logic [4:0]                bin_idx;
   logic [2:0]                bc;
   logic                      accept;
   logic [7:0]                pix_next;
   logic [NUM_BINS-1:0][2:0]  bins_next;
   logic [NUM_ROWS-1:0][7:0]  rows_next;

   assign req_full = (col_ff == LAST_COL) && q_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      grp_cnt = '0;
      for (int u = 0; u < BITS_PER_COL; u++) begin
         if (req_data.column_bits[u]) begin
            grp_cnt[bin_row_of_bit(4'(u))] = grp_cnt[bin_row_of_bit(4'(u))] + 2'd1;
         end
      end
      col_pop = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         col_pop = col_pop + 5'(grp_cnt[r]);
      end
      bc        = bin_col_of_col(col_ff);
      bins_next = bins_ff;
      rows_next = rows_ff;
      bin_idx   = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         bin_idx = 5'(r * BIN_COLS) + 5'(bc);
         bins_next[bin_idx] = bins_ff[bin_idx] + 3'(grp_cnt[r]);
         if (grp_cnt[r] != 2'd0) begin
            rows_next[NUM_ROWS - 1 - r] = rows_ff[NUM_ROWS - 1 - r] | direct_mask(col_ff);
         end
      end
      pix_next = pix_ff + 8'(col_pop);

      q_in.valid            = accept && (col_ff == LAST_COL);
      q_in.rec.char_number  = req_data.char_number;
      q_in.rec.pixel_count  = pix_next;
      q_in.rec.bin_weights  = bins_next;
      q_in.rec.direct_rows  = rows_next;

      col_in  = col_ff;
      pix_in  = pix_ff;
      bins_in = bins_ff;
      rows_in = rows_ff;
      if (accept) begin
         if (col_ff == LAST_COL) begin
            col_in  = '0;
            pix_in  = '0;
            bins_in = '0;
            rows_in = '0;
         end else begin
            col_in  = col_ff + 3'd1;
            pix_in  = pix_next;
            bins_in = bins_next;
            rows_in = rows_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         pix_ff  <= '0;
         bins_ff <= '0;
         rows_ff <= '0;
      end else begin
         col_ff  <= col_in;
         pix_ff  <= pix_in;
         bins_ff <= bins_in;
         rows_ff <= rows_in;
      end
   end

   a_push_on_last: assert property (@(posedge clock) disable iff (reset)
      q_in.valid |=> col_ff == 3'd0 && pix_ff == 8'd0)
      else $error("front state not cleared after a character");

   a_pix_bound: assert property (@(posedge clock) disable iff (reset)
      pix_ff <= MAX_PIX_BEFORE_LAST)
      else $error("pixel count beyond seven columns");

endmodule

>>> design/gds_queue.sv
`timescale 1ns / 1ps
module gds_queue import gds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  gds_qlink_type q_in,
   output logic          q_full,
   output gds_qlink_type q_out,
   input  logic          q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   gds_rec_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push     = q_in.valid && !q_full;
   assign do_pop      = q_pop && (count_ff != '0);
   assign q_out.valid = (count_ff != '0);
   assign q_out.rec   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_in.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_in.valid |-> !q_full)
      else $error("transaction pushed into a full queue");

endmodule

>>> design/gds_back.sv
`timescale 1ns / 1ps
module gds_back import gds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    dense_low,
   input  logic [7:0]    dense_high,
   input  gds_qlink_type q_out,
   output logic          q_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output gds_rsp_type   rsp_data
);

   gds_back_state_type state_ff, state_in;
   gds_rec_type        rec_ff, rec_in;
   logic [2:0]         row_ff, row_in;
   logic               out_valid_ff, out_valid_in;
   gds_rsp_type        out_ff, out_in;
   logic               out_free;
   logic               use_a;
   logic [7:0]         row_a;
   logic [7:0]         row_val;
   logic [4:0]         bin_idx;

   always_comb begin
      use_a = (dense_low <= rec_ff.pixel_count) && (rec_ff.pixel_count < dense_high);
      row_a   = '0;
      bin_idx = '0;
      for (int c = 0; c < BIN_COLS; c++) begin
         bin_idx = 5'(32'(row_ff) * BIN_COLS + c);
         if (rec_ff.bin_weights[bin_idx] >= threshold(row_ff, 3'(c))) begin
            row_a[7 - c] = 1'b1;
         end
      end
      row_val = (use_a ? row_a : rec_ff.direct_rows[row_ff]) & ROW_MASK;
   end

   always_comb begin
      state_in     = state_ff;
      rec_in       = rec_ff;
      row_in       = row_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      q_pop        = 1'b0;
      out_free     = !out_valid_ff || rsp_pop;
      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         BACK_IDLE: begin
            if (q_out.valid) begin
               q_pop    = 1'b1;
               rec_in   = q_out.rec;
               row_in   = '0;
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_in.out_char_number = rec_ff.char_number;
               out_in.row_index       = row_ff;
               out_in.row_bits        = row_val;
               out_in.last_row        = (row_ff == LAST_ROW);
               row_in                 = row_ff + 3'd1;
               if (row_ff == LAST_ROW) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_EMIT |-> row_ff <= LAST_ROW)
      else $error("row counter beyond the last row");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.last_row == (out_ff.row_index == LAST_ROW)))
      else $error("last row flag disagrees with row index");

endmodule

>>> design/glyph_downscale_8x16_to_5x6.sv
`timescale 1ns / 1ps
// Reduces 8x16 glyphs, given as eight column transactions per character, to 5x6 font cells.
// Input channel: req_data carries the character number and one 16-bit column; a transaction
// is taken at each clock edge with req_push high and req_full low. Columns are taken one per
// cycle; req_full can only rise on the eighth column of a character, when the two-entry
// character queue between the accumulator and the row generator is full.
// Result channel: six row transactions per character, rows 0 to 5, last_row set on row 5.
// A character's first row goes through the queue, the row generator's record register and the
// output register to rsp_data; the rest follow one per cycle while rsp_pop is held. The row
// generator is done with a character before the next eight columns are in, so full input rate
// is sustained. When the receiver stalls, the row generator holds its current row in the output
// register, the queue fills, and only then is the eighth column of a further character held
// back. The density window is written through csr_write, csr_index and csr_wdata; the user
// must do so only while the block is idle, which it does not enforce. Synchronous reset clears
// all accumulated state, empties queue and output, and restores the window defaults, 54 and 85.
module glyph_downscale_8x16_to_5x6 import gds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  gds_req_type req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output gds_rsp_type rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]    dense_low_ff, dense_low_in;
   logic [7:0]    dense_high_ff, dense_high_in;
   gds_qlink_type q_in;
   gds_qlink_type q_out;
   logic          q_full;
   logic          q_pop;

   always_comb begin
      dense_low_in  = dense_low_ff;
      dense_high_in = dense_high_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DENSE_LOW:  dense_low_in  = csr_wdata;
            CSR_DENSE_HIGH: dense_high_in = csr_wdata;
            default:        dense_low_in  = dense_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dense_low_ff  <= DENSE_LOW_RESET;
         dense_high_ff <= DENSE_HIGH_RESET;
      end else begin
         dense_low_ff  <= dense_low_in;
         dense_high_ff <= dense_high_in;
      end
   end

   gds_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_in     (q_in)
   );

   gds_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_in   (q_in),
      .q_full (q_full),
      .q_out  (q_out),
      .q_pop  (q_pop)
   );

   gds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .dense_low  (dense_low_ff),
      .dense_high (dense_high_ff),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import gds_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASES        = 7;
   localparam int CHARS_PER_PHASE = 6;

   localparam logic [2:0] BIN_ROW_OF_BIT [16] =
      '{3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0};
   localparam logic [2:0] BIN_COL_OF_COLUMN [8] =
      '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4};
   localparam logic [7:0] MIRROR_MASK [8] =
      '{8'h80, 8'h80, 8'h40, 8'h20, 8'h20, 8'h10, 8'h10, 8'h08};
   localparam logic [2:0] BIN_THRESHOLD [30] =
      '{3'd3, 3'd2, 3'd3, 3'd3, 3'd2,
        3'd3, 3'd2, 3'd3, 3'd3, 3'd2,
        3'd2, 3'd1, 3'd2, 3'd2, 3'd1,
        3'd2, 3'd1, 3'd2, 3'd2, 3'd1,
        3'd3, 3'd2, 3'd3, 3'd3, 3'd2,
        3'd3, 3'd2, 3'd3, 3'd3, 3'd2};

   typedef struct packed {
      logic [7:0]  chr;
      logic [15:0] bits;
      logic        typed;
      logic [7:0]  typed_bits;
   } stim_row_type;

   // Rows with typed set carry the font row byte expected on all six rows of that character.
   localparam stim_row_type DIRECTED_ROWS [24] = '{
      {8'd159, 16'h0000, 1'b0, 8'h00}, {8'd159, 16'h0000, 1'b0, 8'h00},
      {8'd159, 16'h0000, 1'b0, 8'h00}, {8'd159, 16'h0000, 1'b0, 8'h00},
      {8'd159, 16'h0000, 1'b0, 8'h00}, {8'd159, 16'h0000, 1'b0, 8'h00},
      {8'd159, 16'h0000, 1'b0, 8'h00}, {8'd0,   16'h0000, 1'b1, 8'h00},
      {8'd0,   16'hFFFF, 1'b0, 8'h00}, {8'd0,   16'hFFFF, 1'b0, 8'h00},
      {8'd0,   16'hFFFF, 1'b0, 8'h00}, {8'd0,   16'hFFFF, 1'b0, 8'h00},
      {8'd0,   16'hFFFF, 1'b0, 8'h00}, {8'd0,   16'hFFFF, 1'b0, 8'h00},
      {8'd0,   16'hFFFF, 1'b0, 8'h00}, {8'd159, 16'hFFFF, 1'b1, 8'hF8},
      {8'd77,  16'hAAAA, 1'b0, 8'h00}, {8'd77,  16'h5555, 1'b0, 8'h00},
      {8'd77,  16'hAAAA, 1'b0, 8'h00}, {8'd77,  16'h5555, 1'b0, 8'h00},
      {8'd77,  16'hAAAA, 1'b0, 8'h00}, {8'd77,  16'h5555, 1'b0, 8'h00},
      {8'd77,  16'hAAAA, 1'b0, 8'h00}, {8'd77,  16'h5555, 1'b0, 8'h00}
   };

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   gds_req_type req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   gds_rsp_type rsp_data;
   logic        csr_write;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   logic [7:0] window_low;
   logic [7:0] window_high;
   logic [2:0] column_slot;
   logic [7:0] ink_count;
   logic [2:0] glyph_bins [30];
   logic [7:0] mirror_rows [6];
   gds_rsp_type pending_rows [$];
   int mismatches;
   bit idling_on;

   glyph_downscale_8x16_to_5x6 uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic clear_glyph();
      column_slot = '0;
      ink_count = '0;
      foreach (glyph_bins[i]) glyph_bins[i] = '0;
      foreach (mirror_rows[i]) mirror_rows[i] = '0;
   endtask

   task automatic absorb_column(input gds_req_type item, input logic typed,
                                input logic [7:0] typed_bits);
      int bin;
      logic use_dense;
      logic [7:0] row_byte;
      gds_rsp_type row_item;
      for (int u = 0; u < 16; u++) begin
         if (item.column_bits[u]) begin
            bin = BIN_ROW_OF_BIT[u] * 5 + BIN_COL_OF_COLUMN[column_slot];
            ink_count = ink_count + 8'd1;
            glyph_bins[bin] = glyph_bins[bin] + 3'd1;
            mirror_rows[5 - BIN_ROW_OF_BIT[u]] |= MIRROR_MASK[column_slot];
         end
      end
      if (column_slot != LAST_COL) begin
         column_slot = column_slot + 3'd1;
      end else begin
         use_dense = (window_low <= ink_count) && (ink_count < window_high);
         for (int r = 0; r < NUM_ROWS; r++) begin
            row_byte = '0;
            if (use_dense) begin
               for (int c = 0; c < 5; c++) begin
                  if (glyph_bins[r * 5 + c] >= BIN_THRESHOLD[r * 5 + c]) begin
                     row_byte |= 8'h80 >> c;
                  end
               end
            end else begin
               row_byte = mirror_rows[r];
            end
            row_item.out_char_number = item.char_number;
            row_item.row_index = r[2:0];
            row_item.row_bits = typed ? typed_bits : (row_byte & ROW_MASK);
            row_item.last_row = (r[2:0] == LAST_ROW);
            pending_rows.push_back(row_item);
         end
         clear_glyph();
      end
   endtask

   task automatic push_column(input gds_req_type item, input logic typed,
                              input logic [7:0] typed_bits, input bit phase_end);
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      absorb_column(item, typed, typed_bits);
      if (phase_end) begin
         req_push <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic push_random_glyph(input bit phase_end);
      int density;
      int pick;
      gds_req_type item;
      pick = $urandom_range(0, 7);
      case (pick)
         0: density = 0;
         1: density = 16;
         2, 3, 4: density = $urandom_range(6, 10);
         default: density = $urandom_range(0, 16);
      endcase
      for (int col = 0; col < 8; col++) begin
         item.char_number = 8'($urandom_range(0, 159));
         for (int u = 0; u < 16; u++) begin
            item.column_bits[u] = ($urandom_range(0, 15) < density);
         end
         push_column(item, 1'b0, 8'h00, phase_end && col == 7);
      end
   endtask

   task automatic wait_drained();
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [7:0] low, input logic [7:0] high);
      csr_write <= 1'b1;
      csr_index <= CSR_DENSE_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= CSR_DENSE_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_write <= 1'b0;
      window_low = low;
      window_high = high;
   endtask

   task automatic check_row(input gds_rsp_type got);
      gds_rsp_type want;
      if (pending_rows.size() == 0) begin
         $error("unexpected font row: char %0d row %0d", got.out_char_number, got.row_index);
         mismatches++;
      end else begin
         want = pending_rows.pop_front();
         if (got.out_char_number !== want.out_char_number) begin
            $error("out_char_number: expected %0d, got %0d",
                   want.out_char_number, got.out_char_number);
            mismatches++;
         end
         if (got.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
            mismatches++;
         end
         if (got.row_bits !== want.row_bits) begin
            $error("row_bits: expected %h, got %h", want.row_bits, got.row_bits);
            mismatches++;
         end
         if (got.last_row !== want.last_row) begin
            $error("last_row: expected %b, got %b", want.last_row, got.last_row);
            mismatches++;
         end
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) check_row(rsp_data);
         if (idling_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("glyph_downscale_8x16_to_5x6 verification failed");
      $finish;
   end

   initial begin
      gds_req_type item;
      mismatches = 0;
      idling_on = 1'b1;
      window_low = DENSE_LOW_RESET;
      window_high = DENSE_HIGH_RESET;
      clear_glyph();
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_DENSE_LOW;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         item.char_number = DIRECTED_ROWS[i].chr;
         item.column_bits = DIRECTED_ROWS[i].bits;
         push_column(item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_bits, 1'b0);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: write_window(8'd0, 8'd129);
               2: write_window(8'd128, 8'd129);
               3: write_window(8'd0, 8'd0);
               4: write_window(8'd100, 8'd50);
               5: write_window(8'($urandom_range(0, 128)), 8'($urandom_range(0, 129)));
               default: write_window(DENSE_LOW_RESET, DENSE_HIGH_RESET);
            endcase
         end
         if (phase == PHASES - 1) idling_on = 1'b0;
         for (int ch = 0; ch < CHARS_PER_PHASE; ch++) begin
            push_random_glyph(ch == CHARS_PER_PHASE - 1);
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("glyph_downscale_8x16_to_5x6 verification clean");
      end else begin
         $display("glyph_downscale_8x16_to_5x6 verification failed");
      end
      $finish;
   end

endmodule
